[hdl/lme_pkg.sv]
// ----------------------------------------------------------------------------
// LSB masked extractor package
// Shared types and constants for the front, queue and back of the extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package lme_pkg;

	localparam int unsigned LEN_FIELD_BITS = 32;
	localparam int unsigned CNT_W          = 6;
	localparam int unsigned LEN_W          = 32;
	localparam int unsigned BYTE_W         = 8;

	// One classified sample as it waits between front and back.
	typedef struct packed {
		logic frame_start;
		logic carrier;
		logic bit_value;
	} lme_entry_t;

	// One result item.
	typedef struct packed {
		logic [LEN_W-1:0]  message_length;
		logic              empty_message;
		logic              last_byte;
		logic [BYTE_W-1:0] byte_value;
	} lme_result_t;

endpackage

`default_nettype wire

[hdl/lme_front.sv]
// ----------------------------------------------------------------------------
// LSB masked extractor front
// Accepts samples, drops those that carry nothing and reduces the rest to
// a queue entry holding the frame start, the carrier flag and the LSB.
// ----------------------------------------------------------------------------
`default_nettype none

module lme_front
	import lme_pkg::*;
(
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // sample_value[7:0]
	input  wire logic [1:0] s_tuser,   // frame_start, in_mask
	input  wire logic       q_full,
	output logic            q_push,
	output lme_entry_t      q_entry
);

	logic frame_start;
	logic in_mask;

	assign frame_start = s_tuser[0];
	assign in_mask     = s_tuser[1];

	// Unmasked samples away from a frame start change nothing, so they are
	// taken and dropped even while the queue is full.
	assign s_tready = !q_full || !(frame_start || in_mask);
	assign q_push   = s_tvalid && !q_full && (frame_start || in_mask);

	assign q_entry.frame_start = frame_start;
	assign q_entry.carrier     = in_mask;
	assign q_entry.bit_value   = s_tdata[0];

endmodule

`default_nettype wire

[hdl/lme_queue.sv]
// ----------------------------------------------------------------------------
// LSB masked extractor queue
// Small first-in first-out store of classified samples between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module lme_queue
	import lme_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire lme_entry_t push_entry,
	output logic            full,
	output logic            not_empty,
	input  wire logic       pop,
	output lme_entry_t      head
);

	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_QW = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(DEPTH - 1);
	localparam logic [CNT_QW-1:0] DEPTH_CNT = CNT_QW'(DEPTH);

	lme_entry_t        mem_q [DEPTH];
	logic [IDX_W-1:0]  wr_ptr_q;
	logic [IDX_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;

	assign full      = (count_q == DEPTH_CNT);
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/lme_back.sv]
// ----------------------------------------------------------------------------
// LSB masked extractor back
// Decodes the length header, packs message bits into bytes and holds each
// result in an output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lme_back
	import lme_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_not_empty,
	input  wire lme_entry_t q_head,
	output logic            q_pop,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output lme_result_t     m_result
);

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_BODY   = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	phase_t             phase_q,   phase_d;
	logic [CNT_W-1:0]   hcnt_q,    hcnt_d;
	logic [LEN_W-1:0]   hshift_q,  hshift_d;
	logic [2:0]         bib_q,     bib_d;
	logic [BYTE_W-1:0]  bshift_q,  bshift_d;
	logic [LEN_W-1:0]   remain_q,  remain_d;
	logic               res_valid;
	lme_result_t        res;
	logic               out_valid_q;
	lme_result_t        out_q;

	assign q_pop    = q_not_empty && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_result = out_q;

	always_comb begin
		phase_t            ph;
		logic [CNT_W-1:0]  hc;
		logic [LEN_W-1:0]  hs;
		logic [2:0]        bi;
		logic [BYTE_W-1:0] bs;
		logic [LEN_W-1:0]  rm;

		ph = phase_q;
		hc = hcnt_q;
		hs = hshift_q;
		bi = bib_q;
		bs = bshift_q;
		rm = remain_q;
		if (q_head.frame_start) begin
			ph = PH_HEADER;
			hc = '0;
			hs = '0;
			bi = '0;
			bs = '0;
			rm = '0;
		end

		res_valid = 1'b0;
		res       = '0;

		if (q_head.carrier) begin
			unique case (ph)
				PH_HEADER: begin
					hs = {hs[LEN_W-2:0], q_head.bit_value};
					hc = hc + 1'b1;
					if (hc >= CNT_W'(LEN_FIELD_BITS)) begin
						if (hs == '0) begin
							ph = PH_DONE;
							res_valid         = 1'b1;
							res.last_byte     = 1'b1;
							res.empty_message = 1'b1;
						end else begin
							rm = hs;
							bi = '0;
							bs = '0;
							ph = PH_BODY;
						end
					end
				end
				PH_BODY: begin
					bs = {bs[BYTE_W-2:0], q_head.bit_value};
					bi = bi + 1'b1;
					if (bi == '0) begin
						rm = rm - 1'b1;
						res_valid      = 1'b1;
						res.byte_value = bs;
						res.last_byte  = (rm == '0);
						bs = '0;
						if (rm == '0) begin
							ph = PH_DONE;
						end
					end
				end
				default: begin
				end
			endcase
		end
		res.message_length = hs;

		phase_d  = ph;
		hcnt_d   = hc;
		hshift_d = hs;
		bib_d    = bi;
		bshift_d = bs;
		remain_d = rm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			hcnt_q      <= '0;
			hshift_q    <= '0;
			bib_q       <= '0;
			bshift_q    <= '0;
			remain_q    <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (q_pop) begin
				phase_q  <= phase_d;
				hcnt_q   <= hcnt_d;
				hshift_q <= hshift_d;
				bib_q    <= bib_d;
				bshift_q <= bshift_d;
				remain_q <= remain_d;
			end
			if (q_pop && res_valid) begin
				out_valid_q <= 1'b1;
				out_q       <= res;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/lsb_masked_extractor.sv]
// ----------------------------------------------------------------------------
// LSB masked extractor
// Recovers a length-prefixed message from the LSBs of masked image samples.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                         | tuser / tlast
//  s_      | in        | sample_value[7:0]             | tuser: frame_start, in_mask
//  m_      | out       | byte_value, message_length    | tlast: last_byte,
//          |           |                               | tuser: empty_message
//
// One sample is taken per cycle except when held off as below. The
// completing sample enters the queue at its transfer edge; its result
// reaches the output register and m_tvalid when the back pops that entry.
// The front drops unmasked samples away from a frame start at once; others
// wait in the queue, and the back takes one entry per cycle whenever its
// output register is free or being emptied. When the output stalls the
// queue fills, and after that only masked or frame-start samples are held
// off. Reset empties the queue and returns the extractor to the header phase.
// ----------------------------------------------------------------------------
`default_nettype none

module lsb_masked_extractor
	import lme_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // sample_value[7:0]
	input  wire logic [1:0]  s_tuser,   // frame_start[0], in_mask[1]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // byte_value[7:0], message_length[39:8]
	output logic             m_tlast,
	output logic             m_tuser    // empty_message[0]
);

	logic        q_full;
	logic        q_push;
	lme_entry_t  q_entry;
	logic        q_not_empty;
	logic        q_pop;
	lme_entry_t  q_head;
	lme_result_t result;

	lme_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	lme_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.not_empty  (q_not_empty),
		.pop        (q_pop),
		.head       (q_head)
	);

	lme_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_result    (result)
	);

	assign m_tdata = {result.message_length, result.byte_value};
	assign m_tlast = result.last_byte;
	assign m_tuser = result.empty_message;

endmodule

`default_nettype wire

[hdl/lme_checker.sv]
// ----------------------------------------------------------------------------
// LSB masked extractor checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lme_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic        m_tlast,
	input wire logic        m_tuser
);

	// A stalled result transfer keeps its content.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("result changed while stalled");

	// The empty-message result is a final, zero byte.
	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && (m_tdata[7:0] == 8'd0))
		else $error("empty-message result malformed");

	// An empty message reports a zero length.
	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[39:8] == 32'd0))
		else $error("empty-message result with nonzero length");

	// Message bytes only follow a nonzero header.
	a_body_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata[39:8] != 32'd0))
		else $error("message byte with zero length");

endmodule

bind lsb_masked_extractor lme_checker u_lme_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// LSB masked extractor testbench
// Streams framed images into the extractor and checks every message byte it
// returns. A behavioural model follows the header, body and done phases, and
// each output transfer is checked against the oldest predicted byte. Both
// ends idle at random, and the output is held off once for a long stretch
// so that the input side has to stall.
// ----------------------------------------------------------------------------

module testbench;
	import lme_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int IDLE_PCT      = 36;
	localparam int RANDOM_MASKED = 700;
	localparam int DRAIN_CYCLES  = 20;
	localparam int HOLD_AT       = 300;
	localparam int HOLD_CYCLES   = 400;
	localparam int QUIET_FROM    = 600;
	localparam int QUIET_TO      = 800;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_BODY   = 2'd1,
		PH_DONE   = 2'd2
	} extract_phase_t;

	typedef struct packed {
		logic       frame_start;
		logic       in_mask;
		logic [7:0] sample_value;
	} pixel_sample_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [1:0]  s_tuser = '0;   // frame_start[0], in_mask[1]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // byte_value[7:0], message_length[39:8]
	logic        m_tlast;
	logic        m_tuser;        // empty_message[0]

	lsb_masked_extractor uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// Model state of the extractor.
	extract_phase_t ext_phase;
	logic [5:0]     hdr_count;
	logic [31:0]    hdr_shift;
	logic [2:0]     bit_count;
	logic [7:0]     byte_acc;
	logic [31:0]    bytes_left;

	pixel_sample_t  sample_queue[$];
	lme_result_t    awaited_bytes[$];

	logic fs_next = 1'b0;
	int   masked_items = 0;
	int   frames = 0;
	int   accepted_cnt = 0;
	int   stall_cycles = 0;
	int   result_count = 0;
	int   empty_count = 0;
	int   last_count = 0;
	int   mismatches = 0;
	int   cycle_count = 0;
	int   hold_left = 0;
	logic hold_done = 1'b0;
	logic quiet_window;

	assign quiet_window = (accepted_cnt >= QUIET_FROM) && (accepted_cnt < QUIET_TO);

	function automatic void clear_extractor();
		ext_phase  = PH_HEADER;
		hdr_count  = '0;
		hdr_shift  = '0;
		bit_count  = '0;
		byte_acc   = '0;
		bytes_left = '0;
	endfunction

	// Advances the model by one sample; returns 1 when a message byte results.
	function automatic bit extract_lsb(input pixel_sample_t s, output lme_result_t r);
		r = '0;
		if (s.frame_start)
			clear_extractor();
		if (!s.in_mask)
			return 1'b0;
		case (ext_phase)
			PH_HEADER: begin
				hdr_shift = {hdr_shift[30:0], s.sample_value[0]};
				hdr_count = hdr_count + 1'b1;
				if (hdr_count >= LEN_FIELD_BITS) begin
					if (hdr_shift == '0) begin
						ext_phase = PH_DONE;
						r.last_byte = 1'b1;
						r.empty_message = 1'b1;
						return 1'b1;
					end
					bytes_left = hdr_shift;
					bit_count = '0;
					byte_acc = '0;
					ext_phase = PH_BODY;
				end
			end
			PH_BODY: begin
				byte_acc = {byte_acc[6:0], s.sample_value[0]};
				bit_count = bit_count + 1'b1;
				if (bit_count == '0) begin
					r.byte_value = byte_acc;
					r.message_length = hdr_shift;
					byte_acc = '0;
					bytes_left = bytes_left - 1'b1;
					r.last_byte = (bytes_left == '0);
					if (r.last_byte)
						ext_phase = PH_DONE;
					return 1'b1;
				end
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	task automatic push_sample(input logic mask, input logic [7:0] value);
		sample_queue.push_back('{frame_start: fs_next, in_mask: mask, sample_value: value});
		fs_next = 1'b0;
		if (mask)
			masked_items++;
	endtask

	// Embeds the low nbits of val, MSB first, with unmasked samples scattered in.
	task automatic emit_bits(input logic [31:0] val, input int nbits, input int skip_pct);
		logic [7:0] v;
		for (int i = nbits - 1; i >= 0; i--) begin
			while ($urandom_range(99) < skip_pct)
				push_sample(1'b0, 8'($urandom));
			v = 8'($urandom);
			v[0] = val[i];
			push_sample(1'b1, v);
		end
	endtask

	task automatic emit_noise(input int n);
		repeat (n) push_sample(1'($urandom_range(1)), 8'($urandom));
	endtask

	task automatic begin_frame();
		fs_next = 1'b1;
		frames++;
	endtask

	task automatic compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, got);
			mismatches++;
		end
	endtask

	// Input side: offers the queued samples and predicts on each transfer.
	always @(posedge clk or negedge arst_n) begin : sample_driver
		pixel_sample_t cur;
		lme_result_t   res;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			clear_extractor();
		end else begin
			if (s_tvalid && s_tready) begin
				cur.frame_start = s_tuser[0];
				cur.in_mask = s_tuser[1];
				cur.sample_value = s_tdata;
				if (extract_lsb(cur, res))
					awaited_bytes.push_back(res);
				accepted_cnt++;
			end
			if (s_tvalid && !s_tready)
				stall_cycles++;
			if (!s_tvalid || s_tready) begin
				if (sample_queue.size() != 0 && (quiet_window || hold_left != 0 ||
						$urandom_range(99) >= IDLE_PCT)) begin
					cur = sample_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= cur.sample_value;
					s_tuser <= {cur.in_mask, cur.frame_start};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// One long hold-off on the output, so the internal queue fills up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// Output side: checks each transfer against the oldest predicted byte.
	always @(posedge clk or negedge arst_n) begin : byte_monitor
		lme_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				result_count++;
				if (m_tuser)
					empty_count++;
				if (m_tlast)
					last_count++;
				if (awaited_bytes.size() == 0) begin
					$display("%0t: unexpected result: expected none, got byte 0x%0h length 0x%0h",
						$time, m_tdata[7:0], m_tdata[39:8]);
					mismatches++;
				end else begin
					want = awaited_bytes.pop_front();
					compare_field("byte_value", 32'(want.byte_value), 32'(m_tdata[7:0]));
					compare_field("last_byte", 32'(want.last_byte), 32'(m_tlast));
					compare_field("empty_message", 32'(want.empty_message), 32'(m_tuser));
					compare_field("message_length", want.message_length, m_tdata[39:8]);
				end
			end
			m_tready <= (hold_left == 0) && (quiet_window || $urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d bytes still awaited",
				cycle_count, awaited_bytes.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int kind;
		int skip;
		int len;
		int nb;
		int chunk;

		// Zero length gives the empty-message result; later samples are ignored.
		begin_frame();
		emit_bits(32'd0, 32, 0);
		push_sample(1'b1, 8'hFF);
		push_sample(1'b0, 8'hAA);
		// Single byte of all ones, then a masked sample after completion.
		begin_frame();
		emit_bits(32'd1, 32, 0);
		emit_bits(32'hFF, 8, 0);
		push_sample(1'b1, 8'h55);
		// Frame start on an unmasked sample, maximum length, abandoned mid-message.
		begin_frame();
		push_sample(1'b0, 8'h01);
		emit_bits(32'hFFFF_FFFF, 32, 0);
		emit_bits(32'h00, 8, 0);
		emit_bits(32'h5, 3, 0);

		while (masked_items < RANDOM_MASKED + 100) begin
			kind = $urandom_range(99);
			skip = $urandom_range(40);
			begin_frame();
			if (kind < 60) begin
				len = $urandom_range(1, 6);
				emit_bits(32'(len), 32, skip);
				repeat (len) emit_bits($urandom, 8, skip);
				emit_noise($urandom_range(3));
			end else if (kind < 68) begin
				emit_bits(32'd0, 32, skip);
				emit_noise($urandom_range(3));
			end else if (kind < 78) begin
				// The image ends before the message does.
				len = $urandom_range(2, 8);
				emit_bits(32'(len), 32, skip);
				nb = $urandom_range(1, 8 * len - 1);
				while (nb > 0) begin
					chunk = (nb > 32) ? 32 : nb;
					emit_bits($urandom, chunk, skip);
					nb -= chunk;
				end
			end else if (kind < 88) begin
				emit_bits($urandom, $urandom_range(1, 31), skip);
			end else begin
				emit_bits($urandom, 32, skip);
				emit_bits($urandom, 8 * $urandom_range(1, 4), skip);
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (sample_queue.size() != 0 || s_tvalid)
			@(posedge clk);
		while (awaited_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d frames, %0d samples (%0d masked); input stalled for %0d cycles.",
			frames, accepted_cnt, masked_items, stall_cycles);
		$display("Checked %0d message bytes: %0d empty-message, %0d final; %0d mismatches.",
			result_count, empty_count, last_count, mismatches);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[lsb_masked_extractor.f]
hdl/lme_pkg.sv
hdl/lme_front.sv
hdl/lme_queue.sv
hdl/lme_back.sv
hdl/lsb_masked_extractor.sv
hdl/lme_checker.sv
tb/testbench.sv
